>>> src/ffpa_pkg.sv
// shared types and constants of the first-fit pool allocator
package ffpa_pkg;

  localparam int unsigned SIZE_W  = 15;
  localparam int unsigned OFF_W   = 14;
  localparam int unsigned EPOCH_W = 8;

  // request codes
  localparam logic [1:0] REQ_CREATE = 2'd0;
  localparam logic [1:0] REQ_ALLOC  = 2'd1;
  localparam logic [1:0] REQ_FREE   = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADARG = 3'd1;
  localparam logic [2:0] ST_NOPOOL = 3'd2;
  localparam logic [2:0] ST_NOFIT  = 3'd3;
  localparam logic [2:0] ST_NOTIN  = 3'd4;

  // request rounding and split rule
  localparam logic [15:0] ROUND_ADD  = 16'd3;
  localparam logic [15:0] ALIGN_MASK = ~16'd3;
  localparam logic [16:0] MIN_DATA   = 17'd4;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFF_W-1:0]  buf_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [OFF_W-1:0]  data_offset;
    logic [SIZE_W-1:0] byte_count;
  } rsp_t;

  // one header slot of the store, tagged with the pool generation
  typedef struct packed {
    logic               valid;
    logic               busy;
    logic [SIZE_W-1:0]  size;
    logic [EPOCH_W-1:0] epoch;
  } hdr_t;

endpackage

>>> src/ffpa_ram.sv
// generic single-write, single-read ram with registered read data
module ffpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/first_fit_pool_allocator_unit.sv
// top level of the first-fit pool allocator: sequencer, header store and result register
//
// usage
// - in channel: in_valid_i / in_stall_o carry one request word (create, allocate, free);
//   a word is taken at a clock edge with in_valid_i high and in_stall_o low
// - out channel: out_valid_o / out_stall_i carry one result word per request
// - the header store is a ram with one slot per 4-byte word of the pool; each slot is
//   tagged with a pool generation, so apart from a generation wrap a create only bumps the generation and writes slot 0
// - steps after acceptance: a bad or unknown request goes straight to hand-over; a create
//   writes slot 0 first, a free examines its header and releases it if valid, an allocate
//   walks the blocks, one header read per block on the ram port, then marks a fitting block in use
// - one request is in work at a time, so a new word is taken only after the last has been worked;
//   in_stall_o is high from acceptance until the result has been handed to the output register
// - every 256th create wraps the generation and runs a clearing pass over all POOL_BYTES/4
//   slots before slot 0 is written
// - after reset the same clearing pass runs over all POOL_BYTES/4 slots (4096 by default);
//   no request is taken until it ends and no pool exists
// - when the receiver stalls, the result word holds in the output register; one more
//   request may be taken and worked, its result waiting until the register frees
module first_fit_pool_allocator_unit
  import ffpa_pkg::*;
#(
  parameter int unsigned POOL_BYTES   = 16384,
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_word_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_word_o
);

  localparam int unsigned WORDS = POOL_BYTES / 4;
  localparam int unsigned AW    = $clog2(WORDS);
  localparam logic [15:0] HB    = 16'(HEADER_BYTES);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;  // clearing pass over the header store
  localparam logic [2:0] S_IDLE  = 3'd1;  // waiting for a request
  localparam logic [2:0] S_CWR   = 3'd2;  // write the first header of a new pool
  localparam logic [2:0] S_WALK  = 3'd3;  // check the walk position, issue header read
  localparam logic [2:0] S_WCHK  = 3'd4;  // examine the header, advance or split
  localparam logic [2:0] S_WUPD  = 3'd5;  // mark the chosen block in use
  localparam logic [2:0] S_FCHK  = 3'd6;  // examine and release the freed header
  localparam logic [2:0] S_DONE  = 3'd7;  // hand the result to the output register

  function automatic logic [AW-1:0] word_addr(logic [15:0] pos);
    logic [31:0] w;
    w = 32'(pos >> 2);
    return w[AW-1:0];
  endfunction

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       clr_cnt_q, clr_cnt_d;
  logic [EPOCH_W-1:0]  epoch_q, epoch_d;
  logic                create_pend_q, create_pend_d;
  logic                pool_ready_q, pool_ready_d;
  logic [SIZE_W-1:0]   pool_total_q, pool_total_d;
  logic [15:0]         cur_q, cur_d;       // byte position of the header being visited
  logic [15:0]         need_q, need_d;     // block size asked for, header included
  logic [SIZE_W-1:0]   hsize_q, hsize_d;   // final size of the granted block
  rsp_t                res_q, res_d;
  logic                out_valid_q, out_valid_d;
  rsp_t                out_q, out_d;

  // header store port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  hdr_t                ram_wdata;
  logic [AW-1:0]       ram_raddr;
  hdr_t                ram_rdata;

  // shared adder of the walk: position plus header, block or request size
  logic [16:0]         alu_a, alu_b, alu_y;

  logic                accept;
  logic                out_free;
  logic                hvalid;
  logic                fit;
  logic                split_ok;
  logic [15:0]         free_pos;
  logic [15:0]         need_calc;
  logic [16:0]         split_min;

  ffpa_ram #(
    .WIDTH ($bits(hdr_t)),
    .DEPTH (WORDS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // a slot counts only when written under the current pool generation
  assign hvalid    = ram_rdata.valid && (ram_rdata.epoch == epoch_q);
  assign fit       = !ram_rdata.busy && ({1'b0, ram_rdata.size} >= need_q);
  assign split_min = {1'b0, need_q} + {1'b0, HB} + MIN_DATA;

  assign free_pos  = 16'(in_word_i.buf_offset) - HB;
  assign need_calc = ((16'(in_word_i.size_bytes) + ROUND_ADD) & ALIGN_MASK) + HB;

  assign ram_raddr = (state_q == S_IDLE) ? word_addr(free_pos) : word_addr(cur_q);

  always_comb begin
    alu_a = {1'b0, cur_q};
    alu_b = {1'b0, HB};
    if (state_q == S_WCHK) begin
      alu_b = fit ? {1'b0, need_q} : {2'b00, ram_rdata.size};
    end
    alu_y = alu_a + alu_b;
  end

  always_comb begin
    state_d       = state_q;
    clr_cnt_d     = clr_cnt_q;
    epoch_d       = epoch_q;
    create_pend_d = create_pend_q;
    pool_ready_d  = pool_ready_q;
    pool_total_d  = pool_total_q;
    cur_d         = cur_q;
    need_d        = need_q;
    hsize_d       = hsize_q;
    res_d         = res_q;
    out_valid_d   = out_valid_q;
    out_d         = out_q;
    ram_we        = 1'b0;
    ram_waddr     = word_addr(cur_q);
    ram_wdata     = '0;
    split_ok      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        if (clr_cnt_q == AW'(WORDS - 1)) begin
          clr_cnt_d = '0;
          if (create_pend_q) begin
            create_pend_d = 1'b0;
            state_d       = S_CWR;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end

      S_IDLE: begin
        if (accept) begin
          res_d   = '0;
          state_d = S_DONE;
          unique case (in_word_i.req_type)
            REQ_CREATE: begin
              if (in_word_i.size_bytes == '0 ||
                  16'(in_word_i.size_bytes) <= HB ||
                  32'(in_word_i.size_bytes) > 32'(POOL_BYTES)) begin
                res_d.status = ST_BADARG;
              end else begin
                pool_total_d = in_word_i.size_bytes;
                pool_ready_d = 1'b1;
                epoch_d      = epoch_q + EPOCH_W'(1);
                // generation wrap: old tags could match again, so wipe the store
                if (epoch_d == '0) begin
                  create_pend_d = 1'b1;
                  state_d       = S_CLEAR;
                end else begin
                  state_d = S_CWR;
                end
              end
            end
            REQ_ALLOC: begin
              if (!pool_ready_q) begin
                res_d.status = ST_NOPOOL;
              end else if (in_word_i.size_bytes == '0) begin
                res_d.status = ST_NOFIT;
              end else begin
                need_d  = need_calc;
                cur_d   = '0;
                state_d = S_WALK;
              end
            end
            REQ_FREE: begin
              if (!pool_ready_q) begin
                res_d.status = ST_NOPOOL;
              end else if (16'(in_word_i.buf_offset) < HB ||
                           free_pos[1:0] != 2'b00 ||
                           free_pos >= 16'(pool_total_q) ||
                           32'(free_pos >> 2) >= 32'(WORDS)) begin
                res_d.status = ST_NOTIN;
              end else begin
                cur_d   = free_pos;
                state_d = S_FCHK;
              end
            end
            default: begin
              res_d.status = ST_BADARG;
            end
          endcase
        end
      end

      S_CWR: begin
        ram_we          = 1'b1;
        ram_waddr       = '0;
        ram_wdata.valid = 1'b1;
        ram_wdata.busy  = 1'b0;
        ram_wdata.size  = pool_total_q;
        ram_wdata.epoch = epoch_q;
        res_d           = '0;
        res_d.status    = ST_OK;
        state_d         = S_DONE;
      end

      S_WALK: begin
        res_d = '0;
        if (alu_y > {2'b00, pool_total_q}) begin
          res_d.status = ST_NOFIT;
          state_d      = S_DONE;
        end else if (cur_q[1:0] != 2'b00 ||
                     cur_q >= 16'(pool_total_q) ||
                     32'(cur_q >> 2) >= 32'(WORDS)) begin
          res_d.status = ST_NOTIN;
          state_d      = S_DONE;
        end else begin
          state_d = S_WCHK;
        end
      end

      S_WCHK: begin
        res_d = '0;
        if (!hvalid) begin
          res_d.status = ST_NOTIN;
          state_d      = S_DONE;
        end else if (fit) begin
          hsize_d = ram_rdata.size;
          split_ok = ({2'b00, ram_rdata.size} >= split_min) &&
                     (32'(alu_y[15:0] >> 2) < 32'(WORDS));
          if (split_ok) begin
            // remainder becomes a new free block right after the granted one
            ram_we          = 1'b1;
            ram_waddr       = word_addr(alu_y[15:0]);
            ram_wdata.valid = 1'b1;
            ram_wdata.busy  = 1'b0;
            ram_wdata.size  = ram_rdata.size - SIZE_W'(need_q);
            ram_wdata.epoch = epoch_q;
            hsize_d         = SIZE_W'(need_q);
          end
          state_d = S_WUPD;
        end else if (ram_rdata.size == '0) begin
          res_d.status = ST_NOFIT;
          state_d      = S_DONE;
        end else begin
          cur_d = alu_y[15:0];
          if (alu_y == {2'b00, pool_total_q}) begin
            res_d.status = ST_NOFIT;
            state_d      = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end
      end

      S_WUPD: begin
        ram_we            = 1'b1;
        ram_waddr         = word_addr(cur_q);
        ram_wdata.valid   = 1'b1;
        ram_wdata.busy    = 1'b1;
        ram_wdata.size    = hsize_q;
        ram_wdata.epoch   = epoch_q;
        res_d.status      = ST_OK;
        res_d.data_offset = OFF_W'(cur_q + HB);
        res_d.byte_count  = SIZE_W'(16'(hsize_q) - HB);
        state_d           = S_DONE;
      end

      S_FCHK: begin
        res_d = '0;
        if (!hvalid) begin
          res_d.status = ST_NOTIN;
        end else begin
          ram_we            = 1'b1;
          ram_waddr         = word_addr(cur_q);
          ram_wdata.valid   = 1'b1;
          ram_wdata.busy    = 1'b0;
          ram_wdata.size    = ram_rdata.size;
          ram_wdata.epoch   = epoch_q;
          res_d.status      = ST_OK;
          res_d.data_offset = OFF_W'(cur_q + HB);
          res_d.byte_count  = SIZE_W'(16'(ram_rdata.size) - HB);
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_cnt_q     <= '0;
      epoch_q       <= '0;
      create_pend_q <= 1'b0;
      pool_ready_q  <= 1'b0;
      pool_total_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_cnt_q     <= clr_cnt_d;
      epoch_q       <= epoch_d;
      create_pend_q <= create_pend_d;
      pool_ready_q  <= pool_ready_d;
      pool_total_q  <= pool_total_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    need_q  <= need_d;
    hsize_q <= hsize_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // an accepted request always leaves the block busy in the cycle after acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("request accepted but block not busy afterwards");

  // a new result appears only as the sequencer leaves its hand-over state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result raised outside hand-over");

  // outside the clearing pass every header write creates a valid, current header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != S_CLEAR) |-> (ram_wdata.valid && ram_wdata.epoch == epoch_q))
    else $error("header write with stale tag or clear mark");

  // once a pool exists it never goes away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_ready_q |=> pool_ready_q)
    else $error("pool lost");

  // clear counter idles at zero outside the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |-> (clr_cnt_q == '0))
    else $error("clear counter not parked");

endmodule
